[src/smt_pkg.sv]
`timescale 1ns / 1ps

package smt_pkg;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned NCOL_W = 11;
  localparam logic [NCOL_W-1:0] NUM_COLS_RST = 11'd1024;

  typedef struct packed {
    logic [IDX_W-1:0]        in_row;
    logic [IDX_W-1:0]        in_col;
    logic signed [VAL_W-1:0] in_value;
    logic                    in_last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    out_last;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } term_t;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_READ,
    SCAN_EVAL,
    SCAN_FLUSH
  } scan_state_t;

endpackage

[src/smt_store.sv]
`timescale 1ns / 1ps

module smt_store
  import smt_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  term_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output term_t         rd_data
);

  term_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/smt_scan.sv]
`timescale 1ns / 1ps

module smt_scan
  import smt_pkg::*;
#(
  parameter int unsigned MAX_DIM = 1024,
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CW-1:0]     start_cnt,
  input  logic [NCOL_W-1:0] num_cols,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  term_t             rd_data,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  localparam logic [31:0] MaxDimW = 32'(MAX_DIM);

  scan_state_t state, state_next;
  logic [AW-1:0]    idx, idx_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [IDX_W-1:0] cur_col, cur_col_next;
  logic             have_col, have_col_next;
  logic [IDX_W-1:0] nxt_col, nxt_col_next;
  logic             nxt_found, nxt_found_next;
  logic             pend_vld, pend_vld_next;
  term_t            pend, pend_next;
  out_item_t        out_data_next;
  logic             out_valid_next;

  logic out_free;
  logic in_range;
  logic hit;
  logic cand;
  logic take;
  logic pass_end;

  assign out_free = !out_valid || !out_stall;
  assign in_range = ({1'b0, rd_data.col} < num_cols) && (32'(rd_data.col) < MaxDimW);
  assign hit      = have_col && (rd_data.col == cur_col);
  assign cand     = in_range && (!have_col || (rd_data.col > cur_col));
  assign take     = cand && (!nxt_found || (rd_data.col < nxt_col));
  assign pass_end = (CW'(idx) + CW'(1)) == cnt;
  assign rd_addr  = idx;
  assign busy     = (state != SCAN_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SCAN_IDLE;
      pend_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend_vld  <= pend_vld_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    cnt       <= cnt_next;
    cur_col   <= cur_col_next;
    have_col  <= have_col_next;
    nxt_col   <= nxt_col_next;
    nxt_found <= nxt_found_next;
    pend      <= pend_next;
    out_data  <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    cnt_next       = cnt;
    cur_col_next   = cur_col;
    have_col_next  = have_col;
    nxt_col_next   = nxt_col;
    nxt_found_next = nxt_found;
    pend_vld_next  = pend_vld;
    pend_next      = pend;
    out_data_next  = out_data;
    out_valid_next = out_valid && out_stall;
    rd_en          = 1'b0;

    case (state)
      SCAN_IDLE: begin
        if (start) begin
          idx_next       = '0;
          cnt_next       = start_cnt;
          have_col_next  = 1'b0;
          nxt_found_next = 1'b0;
          state_next     = SCAN_READ;
        end
      end
      SCAN_READ: begin
        rd_en      = 1'b1;
        state_next = SCAN_EVAL;
      end
      SCAN_EVAL: begin
        if (!(hit && pend_vld && !out_free)) begin
          if (hit) begin
            if (pend_vld) begin
              out_data_next  = '{out_row: pend.col, out_col: pend.row,
                                 out_value: pend.value, out_last: 1'b0};
              out_valid_next = 1'b1;
            end
            pend_next     = rd_data;
            pend_vld_next = 1'b1;
          end
          if (take) begin
            nxt_col_next   = rd_data.col;
            nxt_found_next = 1'b1;
          end
          if (pass_end) begin
            idx_next = '0;
            if (nxt_found || take) begin
              cur_col_next   = take ? rd_data.col : nxt_col;
              have_col_next  = 1'b1;
              nxt_found_next = 1'b0;
              state_next     = SCAN_READ;
            end else begin
              state_next = SCAN_FLUSH;
            end
          end else begin
            idx_next   = idx + AW'(1);
            state_next = SCAN_READ;
          end
        end
      end
      SCAN_FLUSH: begin
        if (!pend_vld) begin
          state_next = SCAN_IDLE;
        end else if (out_free) begin
          out_data_next  = '{out_row: pend.col, out_col: pend.row,
                             out_value: pend.value, out_last: 1'b1};
          out_valid_next = 1'b1;
          pend_vld_next  = 1'b0;
          state_next     = SCAN_IDLE;
        end
      end
      default: begin
        state_next = SCAN_IDLE;
      end
    endcase
  end

endmodule

[src/sparse_matrix_transpose.sv]
`timescale 1ns / 1ps

// Sparse matrix transpose over (row, column, value) terms. Terms are loaded
// one per cycle while in_stall is low into a store of MAX_TERMS entries
// (further terms are dropped); the term with in_last set ends the load, and
// the block then emits the stored terms with row and column swapped, in
// ascending source column and, within a column, in load order, with
// out_last on the final one. Terms whose column is at or above num_cols, or
// at or above MAX_DIM, are not emitted. in_stall stays high while the emit
// scan runs. The scan makes one pass over the N stored terms per distinct
// in-range column, plus one, reading each term through the single read
// port of the store in a READ state and evaluating it in an EVAL state,
// and ends with a flush state.
// num_cols may be written only while the block is idle.
module sparse_matrix_transpose
  import smt_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 64,
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [NCOL_W-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2((MAX_TERMS > 1) ? MAX_TERMS : 2);
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);

  logic [NCOL_W-1:0] num_cols;
  logic [CW-1:0]     term_count;
  logic              busy;
  logic              accept;
  logic              wr_en;
  logic              start;
  logic [CW-1:0]     start_cnt;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  term_t             rd_data;
  term_t             wr_data;

  assign in_stall  = busy;
  assign accept    = in_valid && !in_stall;
  assign wr_en     = accept && (term_count < CW'(MAX_TERMS));
  assign start     = accept && in_data.in_last;
  assign start_cnt = wr_en ? term_count + CW'(1) : term_count;
  assign wr_data   = '{row: in_data.in_row, col: in_data.in_col, value: in_data.in_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= NUM_COLS_RST;
    end else if (cfg_we) begin
      num_cols <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= '0;
    end else if (start) begin
      term_count <= '0;
    end else if (wr_en) begin
      term_count <= term_count + CW'(1);
    end
  end

  smt_store #(
    .DEPTH(MAX_TERMS),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(term_count[AW-1:0]),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  smt_scan #(
    .MAX_DIM(MAX_DIM),
    .AW(AW),
    .CW(CW)
  ) u_scan (
    .clk(clk),
    .rst(rst),
    .start(start),
    .start_cnt(start_cnt),
    .num_cols(num_cols),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .busy(busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule

[sim/smt_transpose_monitor.sv]
`timescale 1ns / 1ps

module smt_transpose_monitor
  import smt_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 64,
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [NCOL_W-1:0] cfg_wdata,
  output int                pending,
  output int                errors
);

  logic [NCOL_W-1:0] ncols;
  term_t             terms[MAX_TERMS];
  int                term_count;
  out_item_t         transposed_q[$];

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Store one term, and on the final term queue the transposed matrix.
  function automatic void absorb_term(in_item_t t);
    int unsigned span;
    out_item_t   r;
    out_item_t   batch[$];
    if (term_count < MAX_TERMS) begin
      terms[term_count] = '{row: t.in_row, col: t.in_col, value: t.in_value};
      term_count++;
    end
    if (t.in_last) begin
      span = (ncols > MAX_DIM) ? MAX_DIM : ncols;
      for (int c = 0; c < span; c++) begin
        for (int k = 0; k < term_count; k++) begin
          if (terms[k].col == c && batch.size() < MAX_TERMS) begin
            r.out_row = terms[k].col;
            r.out_col = terms[k].row;
            r.out_value = terms[k].value;
            r.out_last = 1'b0;
            batch.push_back(r);
          end
        end
      end
      if (batch.size() > 0) begin
        batch[batch.size()-1].out_last = 1'b1;
      end
      foreach (batch[i]) begin
        transposed_q.push_back(batch[i]);
      end
      term_count = 0;
    end
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (transposed_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: row %0d col %0d value %0h",
                                got.out_row, got.out_col, got.out_value));
      return;
    end
    want = transposed_q.pop_front();
    if (got.out_row !== want.out_row)
      report_mismatch($sformatf("out_row %0h, expected %0h", got.out_row, want.out_row));
    if (got.out_col !== want.out_col)
      report_mismatch($sformatf("out_col %0h, expected %0h", got.out_col, want.out_col));
    if (got.out_value !== want.out_value)
      report_mismatch($sformatf("out_value %0h, expected %0h", got.out_value, want.out_value));
    if (got.out_last !== want.out_last)
      report_mismatch($sformatf("out_last %0b, expected %0b", got.out_last, want.out_last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ncols = NUM_COLS_RST;
      term_count = 0;
      transposed_q.delete();
      errors = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        ncols = cfg_wdata;
      end
      // retire older results before queueing new ones
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
      if (in_valid && !in_stall) begin
        absorb_term(in_data);
      end
      pending <= transposed_q.size();
    end
  end

endmodule

[sim/tb_sparse_matrix_transpose.sv]
`timescale 1ns / 1ps

module tb_sparse_matrix_transpose
  import smt_pkg::*;
;

  localparam int unsigned MAX_TERMS = 64;
  localparam int unsigned MAX_DIM = 1024;
  localparam int SETTLE = 2 * MAX_TERMS * (MAX_TERMS + 1) + 100;
  localparam int WATCH_LIMIT = 4 * SETTLE;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  logic [NCOL_W-1:0] cfg_wdata = '0;

  int pending;
  int errors;
  int out_max = 10;
  int out_hold = 0;
  int max_gap = 10;
  int idle_cycles = 0;
  int rand_sent = 0;
  int unsigned cols_now = NUM_COLS_RST;

  sparse_matrix_transpose #(
    .MAX_TERMS(MAX_TERMS),
    .MAX_DIM  (MAX_DIM)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  smt_transpose_monitor #(
    .MAX_TERMS(MAX_TERMS),
    .MAX_DIM  (MAX_DIM)
  ) u_monitor (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .pending  (pending),
    .errors   (errors)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Draw a fresh stall length after every output transfer.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else if (out_valid && !out_stall) begin
      out_hold <= $urandom_range(0, out_max);
      out_stall <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic in_item_t make_term(int unsigned row, int unsigned col,
                                         logic [VAL_W-1:0] value, bit last);
    in_item_t t;
    t.in_row = row[IDX_W-1:0];
    t.in_col = col[IDX_W-1:0];
    t.in_value = value;
    t.in_last = last;
    return t;
  endfunction

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_term(in_item_t t);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, drain every expected result, then let the scan finish.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cols(int unsigned v);
    cfg_we <= 1'b1;
    cfg_wdata <= v[NCOL_W-1:0];
    cols_now = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned size;
    int unsigned col;
    int          m;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes and in-column load order at the reset column count
    send_term(make_term(0, 0, 32'h8000_0000, 1'b0));
    send_term(make_term(1023, 1023, 32'h7fff_ffff, 1'b0));
    send_term(make_term(5, 1023, 32'hffff_ffff, 1'b0));
    send_term(make_term(3, 0, 32'h0, 1'b0));
    send_term(make_term(1023, 0, 32'h1, 1'b1));
    send_term(make_term(12, 7, 32'd123, 1'b1));

    settle();
    write_cols(0);
    send_term(make_term(1, 0, 32'd5, 1'b0));
    send_term(make_term(2, 9, 32'd6, 1'b1));

    settle();
    write_cols(1);
    send_term(make_term(4, 0, 32'd7, 1'b0));
    send_term(make_term(6, 1, 32'd8, 1'b0));
    send_term(make_term(8, 0, 32'd9, 1'b1));
    send_term(make_term(1, 3, 32'd1, 1'b0));
    send_term(make_term(2, 9, 32'd2, 1'b1));

    settle();
    write_cols(2047);
    send_term(make_term(9, 1023, 32'd10, 1'b0));
    send_term(make_term(10, 512, 32'd11, 1'b0));
    send_term(make_term(11, 1, 32'd12, 1'b1));

    m = 0;
    while (rand_sent < 360) begin
      if (m % 3 == 0) begin
        settle();
        case ((m / 3) % 5)
          0: write_cols(1024);
          1: write_cols($urandom_range(0, 2047));
          2: write_cols(1);
          3: write_cols($urandom_range(2, 16));
          default: write_cols($urandom_range(0, 1) ? 0 : 2047);
        endcase
      end
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
      out_max <= ($urandom_range(0, 3) == 0) ? 0 : 10;
      // mostly small matrices, now and then at or past the store capacity
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_TERMS, MAX_TERMS + 4)
                                         : $urandom_range(1, 16);
      for (int i = 0; i < size; i++) begin
        case ($urandom_range(0, 3))
          0: col = $urandom_range(0, 1023);
          1: col = $urandom_range(0, 7);
          default: col = (cols_now >= 1 && cols_now <= 1024) ?
                         $urandom_range(0, cols_now - 1) : $urandom_range(0, 1023);
        endcase
        send_term(make_term($urandom_range(0, 1023), col, $urandom, i == size - 1));
        rand_sent++;
      end
      m++;
    end

    settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sparse_matrix_transpose.f]
src/smt_pkg.sv
src/smt_store.sv
src/smt_scan.sv
src/sparse_matrix_transpose.sv
sim/smt_transpose_monitor.sv
sim/tb_sparse_matrix_transpose.sv
